// ----- hdl/ffa_pkg.sv -----
// Shared constants, codes and types for the first-fit arena allocator.
package ffa_pkg;

  localparam int ARENA_BYTES_DEF = 32768;
  localparam int GRAN_BYTES      = 8;
  localparam int GRANULES_DEF    = ARENA_BYTES_DEF / GRAN_BYTES;
  localparam int GW_DEF          = $clog2(GRANULES_DEF);
  localparam int WANT_W          = 14;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_RESET   = 2'd2;

  localparam status_t ST_DONE    = 2'd0;
  localparam status_t ST_NOFIT   = 2'd1;
  localparam status_t ST_ZERO    = 2'd2;
  localparam status_t ST_IGNORED = 2'd3;

endpackage

// ----- hdl/first_fit_arena_allocator.sv -----
// First-fit arena allocator: chain-walk sequencer, statistics and header memory.
// Walk: one header per cycle on each chain walk; each item ends with a scan of the whole
//   chain for the largest free block before its result beat.
// Throughput: one item at a time; in_stall stays high until the result beat is taken and
//   drops in the cycle after it is taken.
// Reset: synchronous; header 0 is rewritten in S_INIT, statistics clear, then input opens.
module first_fit_arena_allocator #(
  parameter int ARENA_BYTES = ffa_pkg::ARENA_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  ffa_pkg::op_t             operation,
  input  logic [15:0]              request_bytes,
  input  logic [14:0]              release_offset,
  output logic                     out_valid,
  input  logic                     out_stall,
  output ffa_pkg::status_t         status,
  output logic [14:0]              payload_offset,
  output logic [15:0]              in_use_bytes,
  output logic [15:0]              high_water_bytes,
  output logic [31:0]              failure_count,
  output logic [14:0]              largest_free_bytes
);

  localparam int GRANULES = ARENA_BYTES / ffa_pkg::GRAN_BYTES;
  localparam int GW       = $clog2(GRANULES);
  localparam int UW       = $clog2(GRANULES + 1);
  localparam int WW       = ((GW > ffa_pkg::WANT_W) ? GW : ffa_pkg::WANT_W) + 2;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_FIT_RD  = 4'd2;
  localparam logic [3:0] S_FIT     = 4'd3;
  localparam logic [3:0] S_SPLIT   = 4'd4;
  localparam logic [3:0] S_HEAD    = 4'd5;
  localparam logic [3:0] S_REL_RD  = 4'd6;
  localparam logic [3:0] S_REL     = 4'd7;
  localparam logic [3:0] S_MERGE   = 4'd8;
  localparam logic [3:0] S_REL_WR  = 4'd9;
  localparam logic [3:0] S_SCAN_RD = 4'd10;
  localparam logic [3:0] S_SCAN    = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;
  localparam logic [3:0] S_ARENA   = 4'd13;

  logic [3:0]                 state;
  logic [GW-1:0]              cur;
  logic [GW-1:0]              target;
  logic [GW-1:0]              hsize;
  logic [GW-1:0]              rest_addr;
  logic [GW-1:0]              rest_size;
  logic [GW-1:0]              best;
  logic [GW:0]                pay;
  logic [ffa_pkg::WANT_W-1:0] want;
  logic [UW-1:0]              in_use;
  logic [UW-1:0]              peak;
  logic [31:0]                failures;
  ffa_pkg::status_t           st;

  logic          we;
  logic [GW-1:0] waddr;
  logic [GW:0]   wdata;
  logic [GW-1:0] raddr;
  logic [GW:0]   rdata;

  logic          r_free;
  logic [GW-1:0] r_size;
  logic [GW:0]   nxt;
  logic          chain_end;
  logic [WW-1:0] size_w;
  logic [WW-1:0] want_w;
  logic          fits;
  logic          can_split;
  logic [GW-1:0] best_next;
  logic [16:0]   req_round;
  logic [11:0]   off_gran;
  logic          off_ok;
  logic [UW-1:0] released;
  logic [UW:0]   in_use_sum;
  logic          accept;

  ffa_hdr_ram #(
    .DEPTH (GRANULES),
    .AW    (GW),
    .DW    (GW + 1)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign r_free     = rdata[GW];
  assign r_size     = rdata[GW-1:0];
  assign nxt        = (GW+1)'(cur) + (GW+1)'(r_size) + (GW+1)'(1);
  assign chain_end  = (nxt >= (GW+1)'(GRANULES));
  assign size_w     = WW'(r_size);
  assign want_w     = WW'(want);
  assign fits       = r_free && (size_w >= want_w);
  assign can_split  = (size_w >= want_w + WW'(2));
  assign best_next  = (r_free && (r_size > best)) ? r_size : best;
  assign req_round  = 17'(request_bytes) + 17'd7;
  assign off_gran   = release_offset[14:3];
  assign off_ok     = (release_offset[2:0] == 3'd0) && (off_gran != 12'd0) &&
                      (32'(off_gran) < 32'(GRANULES));
  assign released   = UW'(r_size) + UW'(1);
  assign in_use_sum = (UW+1)'(in_use) + (UW+1)'(hsize) + (UW+1)'(1);
  assign accept     = in_valid && !in_stall;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = {1'b1, hsize};
    unique case (state)
      S_INIT, S_ARENA: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, GW'(GRANULES - 1)};
      end
      S_SPLIT: begin
        we    = 1'b1;
        waddr = rest_addr;
        wdata = {1'b1, rest_size};
      end
      S_HEAD: begin
        we    = 1'b1;
        waddr = cur;
        wdata = {1'b0, hsize};
      end
      S_REL_WR: begin
        we    = 1'b1;
        waddr = target;
        wdata = {1'b1, hsize};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      S_FIT_RD, S_REL_RD, S_SCAN_RD: raddr = '0;
      S_FIT, S_REL, S_MERGE, S_SCAN:  raddr = nxt[GW-1:0];
      default:                        raddr = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      in_use   <= '0;
      peak     <= '0;
      failures <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            pay  <= '0;
            want <= req_round[16:3];
            unique case (operation)
              ffa_pkg::OP_ALLOC: begin
                if (request_bytes == 16'd0) begin
                  st    <= ffa_pkg::ST_ZERO;
                  state <= S_SCAN_RD;
                end else begin
                  state <= S_FIT_RD;
                end
              end
              ffa_pkg::OP_RELEASE: begin
                target <= GW'(32'(off_gran) - 32'd1);
                if (off_ok) begin
                  state <= S_REL_RD;
                end else begin
                  st    <= ffa_pkg::ST_IGNORED;
                  state <= S_SCAN_RD;
                end
              end
              ffa_pkg::OP_RESET: begin
                in_use   <= '0;
                peak     <= '0;
                failures <= '0;
                st       <= ffa_pkg::ST_DONE;
                state    <= S_ARENA;
              end
              default: begin
                st    <= ffa_pkg::ST_IGNORED;
                state <= S_SCAN_RD;
              end
            endcase
          end
        end
        S_ARENA: begin
          state <= S_SCAN_RD;
        end
        S_FIT_RD: begin
          cur   <= '0;
          state <= S_FIT;
        end
        S_FIT: begin
          if (fits) begin
            pay       <= (GW+1)'(cur) + (GW+1)'(1);
            st        <= ffa_pkg::ST_DONE;
            rest_addr <= GW'(WW'(cur) + want_w + WW'(1));
            rest_size <= GW'(size_w - want_w - WW'(1));
            if (can_split) begin
              hsize <= GW'(want_w);
              state <= S_SPLIT;
            end else begin
              hsize <= r_size;
              state <= S_HEAD;
            end
          end else if (chain_end) begin
            failures <= failures + 32'd1;
            st       <= ffa_pkg::ST_NOFIT;
            state    <= S_SCAN_RD;
          end else begin
            cur <= nxt[GW-1:0];
          end
        end
        S_SPLIT: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          in_use <= UW'(in_use_sum);
          if (UW'(in_use_sum) > peak) begin
            peak <= UW'(in_use_sum);
          end
          state <= S_SCAN_RD;
        end
        S_REL_RD: begin
          cur   <= '0;
          state <= S_REL;
        end
        S_REL: begin
          if (cur == target) begin
            if (r_free) begin
              st    <= ffa_pkg::ST_IGNORED;
              state <= S_SCAN_RD;
            end else begin
              hsize  <= r_size;
              in_use <= (in_use >= released) ? in_use - released : '0;
              if (chain_end) begin
                state <= S_REL_WR;
              end else begin
                cur   <= nxt[GW-1:0];
                state <= S_MERGE;
              end
            end
          end else if ((cur > target) || chain_end) begin
            st    <= ffa_pkg::ST_IGNORED;
            state <= S_SCAN_RD;
          end else begin
            cur <= nxt[GW-1:0];
          end
        end
        S_MERGE: begin
          if (r_free) begin
            hsize <= GW'((GW+1)'(hsize) + (GW+1)'(r_size) + (GW+1)'(1));
            if (chain_end) begin
              state <= S_REL_WR;
            end else begin
              cur <= nxt[GW-1:0];
            end
          end else begin
            state <= S_REL_WR;
          end
        end
        S_REL_WR: begin
          st    <= ffa_pkg::ST_DONE;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          cur   <= '0;
          best  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          best <= best_next;
          if (chain_end) begin
            state <= S_DONE;
          end else begin
            cur <= nxt[GW-1:0];
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status             = st;
  assign payload_offset     = 15'({pay, 3'b000});
  assign in_use_bytes       = 16'({in_use, 3'b000});
  assign high_water_bytes   = 16'({peak, 3'b000});
  assign failure_count      = failures;
  assign largest_free_bytes = 15'({best, 3'b000});

  a_peak_covers_use: assert property (@(posedge clk) disable iff (rst)
    peak >= in_use)
    else $error("high-water mark below bytes in use");

  a_fail_step: assert property (@(posedge clk) disable iff (rst)
    (failures != $past(failures)) |->
      ((failures == $past(failures) + 32'd1) || (failures == 32'd0)))
    else $error("failure count moved by other than one");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while a result beat is pending");

  a_split_after_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPLIT) |-> (rest_addr > cur))
    else $error("split remainder header not past the allocated block");

endmodule

// ----- hdl/ffa_hdr_ram.sv -----
// Block header memory: one write port, one registered read port.
module ffa_hdr_ram #(
  parameter int DEPTH = ffa_pkg::GRANULES_DEF,
  parameter int AW    = ffa_pkg::GW_DEF,
  parameter int DW    = ffa_pkg::GW_DEF + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/arena_result_checker.sv -----
// Checker for the first-fit arena allocator: predicts each result beat and compares it.
module arena_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  ffa_pkg::op_t     operation,
  input  logic [15:0]      request_bytes,
  input  logic [14:0]      release_offset,
  input  logic             out_valid,
  input  logic             out_stall,
  input  ffa_pkg::status_t status,
  input  logic [14:0]      payload_offset,
  input  logic [15:0]      in_use_bytes,
  input  logic [15:0]      high_water_bytes,
  input  logic [31:0]      failure_count,
  input  logic [14:0]      largest_free_bytes,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);
  import ffa_pkg::*;

  localparam int unsigned GRANS = GRANULES_DEF;

  typedef struct packed {
    status_t     status;
    logic [14:0] offset;
    logic [15:0] in_use;
    logic [15:0] peak;
    logic [31:0] failures;
    logic [14:0] largest;
  } report_t;

  int unsigned blk_size [GRANS];
  bit          blk_free [GRANS];
  int unsigned used_bytes;
  int unsigned peak_bytes;
  logic [31:0] fail_total;
  report_t     report_q [$];
  int unsigned beats_seen;

  function automatic int unsigned next_gran(int unsigned g);
    return g + 1 + blk_size[g] / GRAN_BYTES;
  endfunction

  function automatic void arena_clear();
    blk_size[0] = GRANS * GRAN_BYTES - GRAN_BYTES;
    blk_free[0] = 1'b1;
    used_bytes  = 0;
  endfunction

  function automatic int unsigned biggest_free();
    int unsigned best;
    int unsigned g;
    best = 0;
    g = 0;
    while (g < GRANS) begin
      if (blk_free[g] && blk_size[g] > best) best = blk_size[g];
      g = next_gran(g);
    end
    return best;
  endfunction

  function automatic bit on_chain(int unsigned target);
    int unsigned g;
    g = 0;
    while (g < GRANS) begin
      if (g == target) return 1'b1;
      if (g > target) return 1'b0;
      g = next_gran(g);
    end
    return 1'b0;
  endfunction

  function automatic report_t arena_step(op_t op, int unsigned req, int unsigned off);
    report_t     r;
    int unsigned want;
    int unsigned g;
    int unsigned rest;
    int unsigned n;
    int unsigned freed;
    bit          found;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (req == 0) begin
          r.status = ST_ZERO;
        end else begin
          want  = (req + 7) & ~32'd7;
          g     = 0;
          found = 1'b0;
          while (g < GRANS && !found) begin
            if (blk_free[g] && blk_size[g] >= want) begin
              if (blk_size[g] >= want + 2 * GRAN_BYTES) begin
                rest = g + 1 + want / GRAN_BYTES;
                if (rest < GRANS) begin
                  blk_size[rest] = blk_size[g] - want - GRAN_BYTES;
                  blk_free[rest] = 1'b1;
                  blk_size[g]    = want;
                end
              end
              blk_free[g] = 1'b0;
              used_bytes += GRAN_BYTES + blk_size[g];
              if (used_bytes > peak_bytes) peak_bytes = used_bytes;
              r.offset = 15'((g + 1) * GRAN_BYTES);
              r.status = ST_DONE;
              found    = 1'b1;
            end else begin
              g = next_gran(g);
            end
          end
          if (!found) begin
            fail_total = fail_total + 32'd1;
            r.status   = ST_NOFIT;
          end
        end
      end
      OP_RELEASE: begin
        r.status = ST_IGNORED;
        if (off >= GRAN_BYTES && off < GRANS * GRAN_BYTES && off % GRAN_BYTES == 0) begin
          g = off / GRAN_BYTES - 1;
          if (on_chain(g) && !blk_free[g]) begin
            blk_free[g] = 1'b1;
            freed       = GRAN_BYTES + blk_size[g];
            used_bytes  = (used_bytes >= freed) ? used_bytes - freed : 0;
            n = next_gran(g);
            while (n < GRANS && blk_free[n]) begin
              blk_size[g] += GRAN_BYTES + blk_size[n];
              n = next_gran(g);
            end
            r.status = ST_DONE;
          end
        end
      end
      OP_RESET: begin
        arena_clear();
        peak_bytes = 0;
        fail_total = '0;
        r.status   = ST_DONE;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.in_use   = used_bytes[15:0];
    r.peak     = peak_bytes[15:0];
    r.failures = fail_total;
    r.largest  = 15'(biggest_free());
    return r;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want_r;
    if (rst) begin
      for (int i = 0; i < GRANS; i++) begin
        blk_size[i] = 0;
        blk_free[i] = 1'b0;
      end
      arena_clear();
      peak_bytes = 0;
      fail_total = '0;
      mismatches = 0;
      beats_seen = 0;
      report_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, payload_offset, in_use_bytes, high_water_bytes, failure_count,
               largest_free_bytes};
        if (report_q.size() == 0) begin
          if (mismatches < 10)
            $display("beat %0d: result with nothing expected: status=%0d offset=%0d",
                     beats_seen, status, payload_offset);
          mismatches++;
        end else begin
          want_r = report_q.pop_front();
          if (got != want_r) begin
            if (mismatches < 10) begin
              $display("beat %0d exp: st=%0d off=%0d use=%0d peak=%0d fail=%0d big=%0d",
                       beats_seen, want_r.status, want_r.offset, want_r.in_use,
                       want_r.peak, want_r.failures, want_r.largest);
              $display("beat %0d act: st=%0d off=%0d use=%0d peak=%0d fail=%0d big=%0d",
                       beats_seen, got.status, got.offset, got.in_use,
                       got.peak, got.failures, got.largest);
            end
            mismatches++;
          end
        end
        beats_seen++;
      end
      if (in_valid && !in_stall)
        report_q.push_back(arena_step(operation, 32'(request_bytes), 32'(release_offset)));
    end
    outstanding = report_q.size();
  end

endmodule

// ----- tb/first_fit_arena_allocator_tb.sv -----
// Testbench top for the first-fit arena allocator: stimulus, receiver stalls and verdict.
module first_fit_arena_allocator_tb;
  import ffa_pkg::*;

  localparam op_t         OP_UNUSED      = 2'd3;
  localparam int unsigned N_RANDOM       = 266;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned TAIL_CYCLES    = 20;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  op_t         operation;
  logic [15:0] request_bytes;
  logic [14:0] release_offset;
  logic        out_valid;
  logic        out_stall;
  status_t     status;
  logic [14:0] payload_offset;
  logic [15:0] in_use_bytes;
  logic [15:0] high_water_bytes;
  logic [31:0] failure_count;
  logic [14:0] largest_free_bytes;
  int unsigned mismatches;
  int unsigned outstanding;

  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  op_t         issued_ops [$];
  op_t         done_op;
  logic [14:0] live_offsets [$];
  logic [14:0] freed_offsets [$];
  int unsigned quiet_cycles;

  first_fit_arena_allocator dut (.*);

  arena_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: decide at the rising edge, drive at the falling edge
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    bit          stall_next;
    out_stall  = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    stall_next = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        stall_next = 1'b1;
        hold_left--;
      end else begin
        stall_next = ($urandom_range(99) < stall_pct);
      end
      @(negedge clk);
      out_stall = stall_next;
    end
  end

  // track live allocations for release stimulus
  always @(posedge clk) begin
    if (rst) begin
      issued_ops.delete();
      live_offsets.delete();
    end else begin
      if (out_valid && !out_stall && issued_ops.size() > 0) begin
        done_op = issued_ops.pop_front();
        if (done_op == OP_RESET) live_offsets.delete();
        else if (done_op == OP_ALLOC && status == ST_DONE) live_offsets.push_back(payload_offset);
      end
      if (in_valid && !in_stall) issued_ops.push_back(operation);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after the beat is taken
  task automatic offer(input op_t op, input logic [15:0] req, input logic [14:0] off);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    operation      = op;
    request_bytes  = req;
    release_offset = off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pick_item(output op_t op, output logic [15:0] req, output logic [14:0] off);
    int unsigned r;
    int unsigned k;
    r   = $urandom_range(99);
    req = 16'($urandom_range(16'hFFFF));
    off = 15'($urandom_range(15'h7FFF));
    if (r < 2) begin
      op = OP_RESET;
    end else if (r < 4) begin
      op = OP_UNUSED;
    end else if (r < 88) begin
      if (live_offsets.size() == 0 || (r < 50 && live_offsets.size() < 40)) begin
        op = OP_ALLOC;
        k  = $urandom_range(99);
        if (k < 4) req = '0;
        else if (k < 60) req = 16'($urandom_range(128, 1));
        else if (k < 85) req = 16'($urandom_range(1024, 129));
        else if (k < 95) req = 16'($urandom_range(8192, 1025));
      end else begin
        op  = OP_RELEASE;
        k   = $urandom_range(live_offsets.size() - 1);
        off = live_offsets[k];
        live_offsets.delete(k);
        freed_offsets.push_back(off);
        if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
      end
    end else begin
      // broken release: null, stray, double, mid-block or unaligned offset
      op = OP_RELEASE;
      k  = $urandom_range(4);
      case (k)
        0: off = '0;
        2: if (freed_offsets.size() > 0)
             off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
        3: if (live_offsets.size() > 0)
             off = live_offsets[$urandom_range(live_offsets.size() - 1)] + 15'd8;
        4: off = 15'($urandom_range(4095, 1) * 8);
        default: ;
      endcase
    end
  endtask

  initial begin
    op_t         op;
    logic [15:0] req;
    logic [14:0] off;
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_ALLOC;
    request_bytes  = '0;
    release_offset = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer(OP_RESET,   16'd0,     15'd0);
    offer(OP_ALLOC,   16'd32760, 15'd0);
    offer(OP_ALLOC,   16'd8,     15'd0);
    offer(OP_ALLOC,   16'd0,     15'd0);
    offer(OP_ALLOC,   16'hFFFF,  15'd0);
    offer(OP_RELEASE, 16'd0,     15'd8);
    offer(OP_RELEASE, 16'd0,     15'd8);
    offer(OP_RELEASE, 16'hFFFF,  15'd0);
    offer(OP_RELEASE, 16'd0,     15'd4);
    offer(OP_RELEASE, 16'd0,     15'h7FFF);
    offer(OP_RELEASE, 16'd0,     15'd12);
    offer(OP_ALLOC,   16'd1,     15'd0);
    offer(OP_ALLOC,   16'd16,    15'd0);
    offer(OP_ALLOC,   16'd8,     15'd0);
    offer(OP_RELEASE, 16'd0,     15'd24);
    offer(OP_RELEASE, 16'd0,     15'd16);
    offer(OP_RELEASE, 16'd0,     15'd8);
    offer(OP_ALLOC,   16'd24,    15'd0);
    offer(OP_UNUSED,  16'hFFFF,  15'h7FFF);
    offer(OP_RESET,   16'd0,     15'd0);
    offer(OP_ALLOC,   16'd32744, 15'd0);
    offer(OP_ALLOC,   16'd8,     15'd0);
    offer(OP_RELEASE, 16'd0,     15'd32760);
    offer(OP_RELEASE, 16'd0,     15'd32752);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % (N_RANDOM / 4) == 0) begin
        case (i / (N_RANDOM / 4))
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 86; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 86; end
          default: begin idle_pct = 24; stall_pct = 24; end
        endcase
      end
      if (i == N_RANDOM / 8) hold_req = 1'b1;
      pick_item(op, req, off);
      offer(op, req, off);
    end
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ffa_pkg.sv
hdl/ffa_hdr_ram.sv
hdl/first_fit_arena_allocator.sv
tb/arena_result_checker.sv
tb/first_fit_arena_allocator_tb.sv
